[sv/dar_pkg.sv]
// Package for the d-pad auto-repeat block: widths, register codes, reset values,
// the configuration and result structs, and the saturating time add.
// No dependencies; every other file imports it.
`default_nettype none

package dar_pkg;

  localparam int TIME_WIDTH      = 48;
  localparam int CFG_WIDTH       = 32;
  localparam int CFG_INDEX_WIDTH = 3;
  localparam int DEADZONE_WIDTH  = 15;
  localparam int STICK_WIDTH     = 16;
  localparam int HAT_WIDTH       = 4;
  localparam int PAD_WIDTH       = 4;

  typedef logic [TIME_WIDTH-1:0] ticks_t;
  typedef logic [CFG_WIDTH-1:0]  cfg_word_t;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_DEADZONE     = 3'd0,
    REG_REPEAT_DELAY = 3'd1,
    REG_SLOW_IVAL    = 3'd2,
    REG_MID_IVAL     = 3'd3,
    REG_FAST_IVAL    = 3'd4,
    REG_FIRST_ACCEL  = 3'd5,
    REG_SECOND_ACCEL = 3'd6
  } cfg_reg_t;

  localparam logic [DEADZONE_WIDTH-1:0] DEADZONE_RST = 15'd20000;
  localparam cfg_word_t REPEAT_DELAY_RST = 32'd6912000;
  localparam cfg_word_t SLOW_IVAL_RST    = 32'd1728000;
  localparam cfg_word_t MID_IVAL_RST     = 32'd1056000;
  localparam cfg_word_t FAST_IVAL_RST    = 32'd614400;
  localparam cfg_word_t FIRST_ACCEL_RST  = 32'd13440000;
  localparam cfg_word_t SECOND_ACCEL_RST = 32'd28800000;

  // Direction of one axis: negative is up or left, positive is down or right.
  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_NEG  = 2'd1,
    DIR_POS  = 2'd2
  } dir_t;

  typedef struct packed {
    logic [DEADZONE_WIDTH-1:0] deadzone;
    cfg_word_t                 repeat_delay;
    cfg_word_t                 slow_ival;
    cfg_word_t                 mid_ival;
    cfg_word_t                 fast_ival;
    cfg_word_t                 first_accel;
    cfg_word_t                 second_accel;
  } dar_cfg_t;

  typedef struct packed {
    logic fire;
    logic pos;
    logic fresh;
  } axis_res_t;

  // Time plus an interval, clamped to the largest timestamp.
  function automatic ticks_t sat_add(input ticks_t a, input cfg_word_t b);
    logic [TIME_WIDTH:0] s;
    s = {1'b0, a} + (TIME_WIDTH+1)'(b);
    return s[TIME_WIDTH] ? '1 : s[TIME_WIDTH-1:0];
  endfunction

endpackage

`default_nettype wire

[sv/dar_if.sv]
// Valid/ready channel interfaces for pad polls and navigation results.
// Depends on dar_pkg for the field widths.
`default_nettype none

interface dar_in_if import dar_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic [HAT_WIDTH-1:0]          hat_bits;
  logic signed [STICK_WIDTH-1:0] stick_x;
  logic signed [STICK_WIDTH-1:0] stick_y;
  logic [PAD_WIDTH-1:0]          pad_buttons;
  ticks_t                        now_ticks;

  modport source (output valid, hat_bits, stick_x, stick_y, pad_buttons, now_ticks,
                  input ready);
  modport sink   (input valid, hat_bits, stick_x, stick_y, pad_buttons, now_ticks,
                  output ready);
endinterface

interface dar_out_if;
  logic valid;
  logic ready;
  logic vert_fire;
  logic vert_is_down;
  logic vert_fresh;
  logic horiz_fire;
  logic horiz_is_right;
  logic horiz_fresh;

  modport source (output valid, vert_fire, vert_is_down, vert_fresh,
                  horiz_fire, horiz_is_right, horiz_fresh, input ready);
  modport sink   (input valid, vert_fire, vert_is_down, vert_fresh,
                  horiz_fire, horiz_is_right, horiz_fresh, output ready);
endinterface

`default_nettype wire

[sv/dar_dir_decode.sv]
// Combines hat, stick and d-pad bits of one poll into a direction per axis.
// Depends on dar_pkg.
`default_nettype none

module dar_dir_decode import dar_pkg::*; (
  input  wire logic [HAT_WIDTH-1:0]          hat_bits,
  input  wire logic signed [STICK_WIDTH-1:0] stick_x,
  input  wire logic signed [STICK_WIDTH-1:0] stick_y,
  input  wire logic [PAD_WIDTH-1:0]          pad_buttons,
  input  wire logic [DEADZONE_WIDTH-1:0]     deadzone,
  output dir_t                               vert_dir,
  output dir_t                               horiz_dir
);

  logic signed [STICK_WIDTH:0] dz_s;
  logic signed [STICK_WIDTH:0] sx_e;
  logic signed [STICK_WIDTH:0] sy_e;
  logic up, down, left, right;

  // One extra bit so that the negated deadzone cannot overflow.
  assign dz_s = {{(STICK_WIDTH+1-DEADZONE_WIDTH){1'b0}}, deadzone};
  assign sx_e = {stick_x[STICK_WIDTH-1], stick_x};
  assign sy_e = {stick_y[STICK_WIDTH-1], stick_y};

  assign up    = hat_bits[0] || (sy_e < -dz_s) || pad_buttons[0];
  assign down  = hat_bits[2] || (sy_e >  dz_s) || pad_buttons[1];
  assign left  = hat_bits[3] || (sx_e < -dz_s) || pad_buttons[2];
  assign right = hat_bits[1] || (sx_e >  dz_s) || pad_buttons[3];

  // Up beats down and left beats right.
  assign vert_dir  = up   ? DIR_NEG : (down  ? DIR_POS : DIR_NONE);
  assign horiz_dir = left ? DIR_NEG : (right ? DIR_POS : DIR_NONE);

endmodule

`default_nettype wire

[sv/dar_axis.sv]
// Repeat timer of one axis: held direction, hold start and next repeat time.
// Computes the event for the item in the input register. Depends on dar_pkg.
`default_nettype none

module dar_axis import dar_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     step,
  input  wire dir_t     dir,
  input  wire ticks_t   now,
  input  wire dar_cfg_t cfg,
  output axis_res_t     res
);

  dir_t   held_r, held_nxt;
  ticks_t next_r, next_nxt;
  ticks_t start_r, start_nxt;

  logic                active, fresh, due;
  logic [TIME_WIDTH:0] diff;
  ticks_t              hold;
  logic                below_first, below_second;
  ticks_t              at_delay, at_slow, at_mid, at_fast, at_repeat;

  assign active = (dir != DIR_NONE);
  assign fresh  = (dir != held_r);
  assign due    = (now >= next_r);

  // A timestamp earlier than the hold start counts as a zero-length hold.
  assign diff = {1'b0, now} - {1'b0, start_r};
  assign hold = diff[TIME_WIDTH] ? '0 : diff[TIME_WIDTH-1:0];

  assign below_first  = (hold < ticks_t'(cfg.first_accel));
  assign below_second = (hold < ticks_t'(cfg.second_accel));

  // All candidate repeat times are formed in parallel and selected afterwards.
  assign at_delay = sat_add(now, cfg.repeat_delay);
  assign at_slow  = sat_add(now, cfg.slow_ival);
  assign at_mid   = sat_add(now, cfg.mid_ival);
  assign at_fast  = sat_add(now, cfg.fast_ival);
  assign at_repeat = below_first ? at_slow : (below_second ? at_mid : at_fast);

  always_comb begin
    res       = '0;
    held_nxt  = DIR_NONE;
    next_nxt  = next_r;
    start_nxt = start_r;
    if (active) begin
      held_nxt = dir;
      if (fresh) begin
        res.fire  = 1'b1;
        start_nxt = now;
        next_nxt  = at_delay;
      end else if (due) begin
        res.fire = 1'b1;
        next_nxt = at_repeat;
      end
    end
    res.pos   = res.fire && (dir == DIR_POS);
    res.fresh = res.fire && fresh;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r  <= DIR_NONE;
      next_r  <= '0;
      start_r <= '0;
    end else if (step) begin
      held_r  <= held_nxt;
      next_r  <= next_nxt;
      start_r <= start_nxt;
    end
  end

endmodule

`default_nettype wire

[sv/dpad_auto_repeat_accel.sv]
// Auto-repeat for gamepad navigation with hold acceleration.
// Depends on dar_pkg, dar_if, dar_dir_decode and dar_axis.
//
// in_ch carries one pad poll per item: hat bits, two stick axes, d-pad buttons
// and a timestamp in ticks. out_ch returns exactly one result per poll with a
// fire, direction and fresh-press flag for each axis. An item is moved when
// valid and ready are both high.
// The poll is decoded into two directions as it enters the input register;
// from there both axis timers compare and update against their state and the
// result is captured in the output register, which drives out_ch.valid. One
// poll is taken every cycle while the output does not stall; the path that
// sets the clock is the 48-bit hold subtract, threshold compare and
// repeat-time select in each timer.
// While a result waits and out_ch.ready is low, both registers hold and
// in_ch.ready drops once the input register is full as well; axis state only
// advances as an item moves into the output register.
// cfg_we writes cfg_data into register cfg_index (0 deadzone, 1 repeat delay,
// 2 to 4 slow, mid, fast interval, 5 and 6 acceleration thresholds); other
// indexes are ignored. Write only while the block is idle.
// Synchronous reset loads the default timings and clears all held directions.
`default_nettype none

module dpad_auto_repeat_accel import dar_pkg::*; (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  dar_in_if.sink                          in_ch,
  dar_out_if.source                       out_ch,
  input  wire logic                       cfg_we,
  input  wire logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  wire cfg_word_t                  cfg_data
);

  dar_cfg_t cfg_r;

  dir_t   in_vdir, in_hdir;
  logic   s1_valid_r;
  dir_t   s1_vdir_r, s1_hdir_r;
  ticks_t s1_now_r;

  logic      out_valid_r;
  axis_res_t vert_res_r, horiz_res_r;
  axis_res_t vert_res, horiz_res;

  logic advance, step, in_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.deadzone     <= DEADZONE_RST;
      cfg_r.repeat_delay <= REPEAT_DELAY_RST;
      cfg_r.slow_ival    <= SLOW_IVAL_RST;
      cfg_r.mid_ival     <= MID_IVAL_RST;
      cfg_r.fast_ival    <= FAST_IVAL_RST;
      cfg_r.first_accel  <= FIRST_ACCEL_RST;
      cfg_r.second_accel <= SECOND_ACCEL_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DEADZONE:     cfg_r.deadzone     <= cfg_data[DEADZONE_WIDTH-1:0];
        REG_REPEAT_DELAY: cfg_r.repeat_delay <= cfg_data;
        REG_SLOW_IVAL:    cfg_r.slow_ival    <= cfg_data;
        REG_MID_IVAL:     cfg_r.mid_ival     <= cfg_data;
        REG_FAST_IVAL:    cfg_r.fast_ival    <= cfg_data;
        REG_FIRST_ACCEL:  cfg_r.first_accel  <= cfg_data;
        REG_SECOND_ACCEL: cfg_r.second_accel <= cfg_data;
        default: ;
      endcase
    end
  end

  dar_dir_decode u_decode (
    .hat_bits    (in_ch.hat_bits),
    .stick_x     (in_ch.stick_x),
    .stick_y     (in_ch.stick_y),
    .pad_buttons (in_ch.pad_buttons),
    .deadzone    (cfg_r.deadzone),
    .vert_dir    (in_vdir),
    .horiz_dir   (in_hdir)
  );

  assign advance     = !out_valid_r || out_ch.ready;
  assign step        = s1_valid_r && advance;
  assign in_ch.ready = !s1_valid_r || advance;
  assign in_take     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_vdir_r <= in_vdir;
      s1_hdir_r <= in_hdir;
      s1_now_r  <= in_ch.now_ticks;
    end
  end

  dar_axis u_vert (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .dir   (s1_vdir_r),
    .now   (s1_now_r),
    .cfg   (cfg_r),
    .res   (vert_res)
  );

  dar_axis u_horiz (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .dir   (s1_hdir_r),
    .now   (s1_now_r),
    .cfg   (cfg_r),
    .res   (horiz_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      vert_res_r  <= vert_res;
      horiz_res_r <= horiz_res;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.vert_fire      = vert_res_r.fire;
  assign out_ch.vert_is_down   = vert_res_r.pos;
  assign out_ch.vert_fresh     = vert_res_r.fresh;
  assign out_ch.horiz_fire     = horiz_res_r.fire;
  assign out_ch.horiz_is_right = horiz_res_r.pos;
  assign out_ch.horiz_fresh    = horiz_res_r.fresh;

  // An item in the input register is never dropped while the output stalls.
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !advance |=> s1_valid_r)
    else $error("input register lost an item during a stall");

  // An item that leaves the input register shows up as a result.
  a_s1_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> out_valid_r)
    else $error("stepped item did not reach the output register");

  // An accepted poll is in the input register in the next cycle.
  a_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> s1_valid_r)
    else $error("accepted item missing from the input register");

  // Direction and fresh flags are only set on an event.
  a_quiet_vert: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !vert_res_r.fire |-> !vert_res_r.pos && !vert_res_r.fresh)
    else $error("vertical flags set without an event");

  a_quiet_horiz: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !horiz_res_r.fire |-> !horiz_res_r.pos && !horiz_res_r.fresh)
    else $error("horizontal flags set without an event");

endmodule

`default_nettype wire

[tb/dpad_auto_repeat_accel_tb.sv]
// Testbench for dpad_auto_repeat_accel: sends pad polls, predicts both axis
// repeat timers in its own model, and checks every navigation result field.
// Depends on dar_pkg and the dar_in_if / dar_out_if channel interfaces.

module dpad_auto_repeat_accel_tb import dar_pkg::*; ();

  localparam int CLK_PERIOD        = 12;
  localparam int RESET_CYCLES      = 12;
  localparam int QUIET_LIMIT       = 2000;
  localparam int PIPE_DRAIN        = 6;
  localparam int HOLD_OFF_CYCLES   = 200;
  localparam int POLLS_PER_PHASE   = 230;
  localparam int MAX_PRINTED_FAULTS = 40;
  localparam int AX_VERT           = 0;
  localparam int AX_HORIZ          = 1;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_UNMAPPED = 3'd7;
  localparam ticks_t TICKS_MAX = '1;

  localparam logic [HAT_WIDTH-1:0] HAT_UP    = 4'b0001;
  localparam logic [HAT_WIDTH-1:0] HAT_RIGHT = 4'b0010;
  localparam logic [HAT_WIDTH-1:0] HAT_DOWN  = 4'b0100;
  localparam logic [HAT_WIDTH-1:0] HAT_LEFT  = 4'b1000;
  localparam logic [PAD_WIDTH-1:0] PAD_UP    = 4'b0001;
  localparam logic [PAD_WIDTH-1:0] PAD_DOWN  = 4'b0010;
  localparam logic [PAD_WIDTH-1:0] PAD_LEFT  = 4'b0100;
  localparam logic [PAD_WIDTH-1:0] PAD_RIGHT = 4'b1000;

  localparam dar_cfg_t CFG_DEFAULTS = '{
    deadzone:     DEADZONE_RST,
    repeat_delay: REPEAT_DELAY_RST,
    slow_ival:    SLOW_IVAL_RST,
    mid_ival:     MID_IVAL_RST,
    fast_ival:    FAST_IVAL_RST,
    first_accel:  FIRST_ACCEL_RST,
    second_accel: SECOND_ACCEL_RST
  };

  typedef struct packed {
    axis_res_t vert;
    axis_res_t horiz;
  } nav_res_t;

  logic                       clk;
  logic                       rst_n;
  logic                       cfg_we;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index;
  cfg_word_t                  cfg_data;

  dar_in_if  in_ch();
  dar_out_if out_ch();

  dpad_auto_repeat_accel u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Model of the block: configuration and per-axis repeat state.
  dar_cfg_t model_cfg;
  dir_t     held_dir   [2];
  ticks_t   next_fire  [2];
  ticks_t   hold_start [2];

  nav_res_t pending_nav [$];
  ticks_t   poll_clock;
  int       errors = 0;
  int       polls_sent = 0;
  int       results_checked = 0;
  int       fires_seen = 0;
  int       quiet_cycles = 0;
  bit       sender_idle_on = 1'b1;
  bit       receiver_idle_on = 1'b1;
  bit       hold_off_req = 1'b0;

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  function automatic ticks_t add_clamped(input ticks_t base, input cfg_word_t span);
    logic [TIME_WIDTH:0] total;
    total = {1'b0, base} + {{(TIME_WIDTH - CFG_WIDTH + 1){1'b0}}, span};
    return (total > TICKS_MAX) ? TICKS_MAX : total[TIME_WIDTH-1:0];
  endfunction

  function automatic axis_res_t advance_axis(input int ax, input dir_t d, input ticks_t now);
    axis_res_t r;
    bit        fresh;
    ticks_t    hold;
    cfg_word_t ival;
    r = '0;
    if (d == DIR_NONE) begin
      held_dir[ax] = DIR_NONE;
      return r;
    end
    fresh = (d != held_dir[ax]);
    if (fresh) begin
      r.fire = 1'b1;
      hold_start[ax] = now;
      next_fire[ax] = add_clamped(now, model_cfg.repeat_delay);
    end else if (now >= next_fire[ax]) begin
      // A hold that lands exactly on a threshold already takes the faster step.
      hold = (now >= hold_start[ax]) ? now - hold_start[ax] : '0;
      if (hold < model_cfg.first_accel) ival = model_cfg.slow_ival;
      else if (hold < model_cfg.second_accel) ival = model_cfg.mid_ival;
      else ival = model_cfg.fast_ival;
      r.fire = 1'b1;
      next_fire[ax] = add_clamped(now, ival);
    end
    held_dir[ax] = d;
    if (r.fire) begin
      r.pos = (d == DIR_POS);
      r.fresh = fresh;
    end
    return r;
  endfunction

  function automatic nav_res_t predict_navigation(
    input logic [HAT_WIDTH-1:0] hat, input logic signed [STICK_WIDTH-1:0] sx,
    input logic signed [STICK_WIDTH-1:0] sy, input logic [PAD_WIDTH-1:0] pad,
    input ticks_t now);
    int       dz;
    bit       up, down, left, right;
    dir_t     dv, dh;
    nav_res_t r;
    dz = int'(model_cfg.deadzone);
    up    = |(hat & HAT_UP)    || int'(sy) < -dz || |(pad & PAD_UP);
    down  = |(hat & HAT_DOWN)  || int'(sy) >  dz || |(pad & PAD_DOWN);
    left  = |(hat & HAT_LEFT)  || int'(sx) < -dz || |(pad & PAD_LEFT);
    right = |(hat & HAT_RIGHT) || int'(sx) >  dz || |(pad & PAD_RIGHT);
    dv = up ? DIR_NEG : (down ? DIR_POS : DIR_NONE);
    dh = left ? DIR_NEG : (right ? DIR_POS : DIR_NONE);
    r.vert = advance_axis(AX_VERT, dv, now);
    r.horiz = advance_axis(AX_HORIZ, dh, now);
    return r;
  endfunction

  function automatic dar_cfg_t draw_config(input int unsigned span);
    dar_cfg_t c;
    c.deadzone     = 15'($urandom);
    c.repeat_delay = $urandom_range(0, 4 * span);
    c.slow_ival    = $urandom_range(0, span);
    c.mid_ival     = $urandom_range(0, span);
    c.fast_ival    = $urandom_range(0, span);
    c.first_accel  = $urandom_range(0, 8 * span);
    c.second_accel = $urandom_range(c.first_accel, 16 * span);
    return c;
  endfunction

  task automatic report_mismatch(input string what);
    errors++;
    if (errors <= MAX_PRINTED_FAULTS) $display("MISMATCH at %0t: %s", $time, what);
  endtask

  task automatic check_flag(input string name, input logic got, input logic want);
    if (got !== want)
      report_mismatch($sformatf("result %0d: %s is %b, expected %b",
                                results_checked, name, got, want));
  endtask

  // Called just after a falling edge; returns just after a falling edge with valid low.
  task automatic send_poll(
    input logic [HAT_WIDTH-1:0] hat, input logic signed [STICK_WIDTH-1:0] sx,
    input logic signed [STICK_WIDTH-1:0] sy, input logic [PAD_WIDTH-1:0] pad,
    input ticks_t now);
    int gap;
    gap = sender_idle_on ? $urandom_range(0, 4) : 0;
    repeat (gap) @(negedge clk);
    in_ch.hat_bits    = hat;
    in_ch.stick_x     = sx;
    in_ch.stick_y     = sy;
    in_ch.pad_buttons = pad;
    in_ch.now_ticks   = now;
    in_ch.valid       = 1'b1;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    pending_nav.insert(pending_nav.size(), predict_navigation(hat, sx, sy, pad, now));
    polls_sent++;
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_nav.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx, input cfg_word_t value);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_DEADZONE:     model_cfg.deadzone     = value[DEADZONE_WIDTH-1:0];
      REG_REPEAT_DELAY: model_cfg.repeat_delay = value;
      REG_SLOW_IVAL:    model_cfg.slow_ival    = value;
      REG_MID_IVAL:     model_cfg.mid_ival     = value;
      REG_FAST_IVAL:    model_cfg.fast_ival    = value;
      REG_FIRST_ACCEL:  model_cfg.first_accel  = value;
      REG_SECOND_ACCEL: model_cfg.second_accel = value;
      default: ;
    endcase
  endtask

  task automatic write_config(input dar_cfg_t c);
    write_reg(REG_DEADZONE, cfg_word_t'(c.deadzone));
    write_reg(REG_REPEAT_DELAY, c.repeat_delay);
    write_reg(REG_SLOW_IVAL, c.slow_ival);
    write_reg(REG_MID_IVAL, c.mid_ival);
    write_reg(REG_FAST_IVAL, c.fast_ival);
    write_reg(REG_FIRST_ACCEL, c.first_accel);
    write_reg(REG_SECOND_ACCEL, c.second_accel);
  endtask

  // Adds one way of pressing direction d on an axis; sometimes the opposite
  // way is pressed too, which the negative direction must win.
  task automatic place_dir(input dir_t d, input bit vertical,
                           inout logic [HAT_WIDTH-1:0] hat, inout logic [PAD_WIDTH-1:0] pad,
                           inout logic signed [STICK_WIDTH-1:0] stick);
    int dz, src;
    logic [HAT_WIDTH-1:0] hat_neg, hat_pos;
    logic [PAD_WIDTH-1:0] pad_neg, pad_pos;
    dz = int'(model_cfg.deadzone);
    hat_neg = vertical ? HAT_UP : HAT_LEFT;
    hat_pos = vertical ? HAT_DOWN : HAT_RIGHT;
    pad_neg = vertical ? PAD_UP : PAD_LEFT;
    pad_pos = vertical ? PAD_DOWN : PAD_RIGHT;
    src = $urandom_range(0, 2);
    case (d)
      DIR_NEG: begin
        if (src == 0) hat |= hat_neg;
        else if (src == 1) pad |= pad_neg;
        else stick = 16'(-int'($urandom_range(32768, dz + 1)));
        if ($urandom_range(0, 3) == 0) begin
          if ($urandom_range(0, 1) == 1) hat |= hat_pos;
          else pad |= pad_pos;
        end
      end
      DIR_POS: begin
        if (src == 0 || dz >= 32767) hat |= hat_pos;
        else if (src == 1) pad |= pad_pos;
        else stick = 16'($urandom_range(32767, dz + 1));
      end
      default: ;
    endcase
  endtask

  // A direction pair held for several polls, with the means of pressing
  // redrawn on every poll and the clock moving forward by up to max_step.
  task automatic send_gesture(input int polls, input int unsigned max_step);
    dir_t vd, hd;
    int dz;
    logic [HAT_WIDTH-1:0] hat;
    logic [PAD_WIDTH-1:0] pad;
    logic signed [STICK_WIDTH-1:0] sx, sy;
    vd = dir_t'($urandom_range(0, 2));
    hd = dir_t'($urandom_range(0, 2));
    for (int k = 0; k < polls; k++) begin
      dz = int'(model_cfg.deadzone);
      hat = '0;
      pad = '0;
      sx = 16'(int'($urandom_range(0, 2 * dz)) - dz);
      sy = 16'(int'($urandom_range(0, 2 * dz)) - dz);
      place_dir(vd, 1'b1, hat, pad, sy);
      place_dir(hd, 1'b0, hat, pad, sx);
      poll_clock = poll_clock + $urandom_range(0, max_step);
      send_poll(hat, sx, sy, pad, poll_clock);
    end
  endtask

  task automatic send_noise(input int unsigned max_step);
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) poll_clock = ticks_t'({$urandom, $urandom});
    else if (pick == 1) poll_clock = poll_clock - $urandom_range(0, max_step);
    else poll_clock = poll_clock + $urandom_range(0, max_step);
    send_poll(4'($urandom), 16'($urandom), 16'($urandom), 4'($urandom), poll_clock);
  endtask

  // Default timings: each source of each direction, deadzone edges, priority,
  // repeat due on the exact tick, and both acceleration thresholds hit exactly.
  task automatic test_directed_defaults();
    localparam ticks_t T0 = 48'd5000;
    send_poll('0, 0, 0, '0, T0);
    send_poll(HAT_UP, 0, 0, '0, T0);
    send_poll(HAT_UP, 0, 0, '0, T0 + REPEAT_DELAY_RST - 1);
    send_poll(HAT_UP, 0, 0, '0, T0 + REPEAT_DELAY_RST);
    send_poll(HAT_UP, 0, 0, '0, T0 + FIRST_ACCEL_RST);
    send_poll(HAT_UP, 0, 0, '0, T0 + SECOND_ACCEL_RST);
    send_poll(HAT_UP, 0, 0, '0, T0 + SECOND_ACCEL_RST + FAST_IVAL_RST);
    poll_clock = T0 + 48'd40_000_000;
    send_poll('0, 0, 0, '0, poll_clock);
    send_poll('0, -20000, 20000, '0, poll_clock + 1000);
    send_poll('0, -20001, 20001, '0, poll_clock + 2000);
    send_poll('0, 20001, -20001, '0, poll_clock + 3000);
    send_poll('0, 32767, -32768, '0, poll_clock + 4000);
    send_poll(HAT_UP | HAT_DOWN | HAT_LEFT | HAT_RIGHT, 0, 0, '0, poll_clock + 5000);
    send_poll('0, 0, 0, PAD_DOWN | PAD_RIGHT, poll_clock + 6000);
    send_poll('0, 0, 0, PAD_UP | PAD_LEFT, poll_clock + 7000);
    send_poll('0, 0, 0, PAD_UP | PAD_DOWN | PAD_LEFT | PAD_RIGHT, poll_clock + 8000);
    send_poll('0, -32768, 32767, '0, poll_clock + 9000);
    send_poll('0, 0, 0, '0, poll_clock + 10000);
    send_poll(HAT_DOWN | HAT_RIGHT, 0, 0, '0, poll_clock + 11000);
  endtask

  task automatic test_register_extremes();
    dar_cfg_t c;
    wait_drained();
    c = '0;
    write_config(c);
    // Zero deadzone and timings: any deflection counts and repeats unless time steps back.
    send_poll('0, 1, -1, '0, 48'd1000);
    send_poll('0, 1, -1, '0, 48'd1000);
    send_poll('0, 1, -1, '0, 48'd400);
    send_poll('0, 1, -1, '0, 48'd400);
    send_poll('0, 0, 0, '0, 48'd401);
    wait_drained();
    c = '1;
    write_config(c);
    // Only the low 15 data bits reach the deadzone.
    write_reg(REG_DEADZONE, '1);
    send_poll('0, 32767, -32767, '0, TICKS_MAX - 20);
    send_poll('0, -32768, -32768, '0, TICKS_MAX - 10);
    send_poll('0, -32768, 32767, '0, TICKS_MAX - 1);
    send_poll(HAT_UP, -32768, 0, '0, TICKS_MAX - 1);
    send_poll(HAT_UP, -32768, 0, '0, TICKS_MAX);
    send_poll(HAT_UP | HAT_LEFT, 0, 0, '0, TICKS_MAX);
  endtask

  task automatic test_unmapped_register();
    wait_drained();
    write_config(CFG_DEFAULTS);
    write_reg(REG_UNMAPPED, '0);
    send_poll('0, 100, -100, '0, 48'd10);
    send_poll('0, 0, 0, PAD_DOWN, 48'd20);
    send_poll('0, 0, 0, PAD_DOWN, 48'd30);
    send_poll('0, 0, 0, '0, 48'd40);
  endtask

  // The receiver stops for a long stretch while polls keep coming, then the
  // sender holds back until every result is in, then a stretch with no idling.
  task automatic test_backpressure();
    wait_drained();
    write_config(draw_config(20));
    poll_clock = 48'd100;
    sender_idle_on = 1'b0;
    hold_off_req = 1'b1;
    repeat (4) send_gesture(10, 20);
    wait_drained();
    receiver_idle_on = 1'b0;
    repeat (3) send_gesture(8, 20);
    receiver_idle_on = 1'b1;
    sender_idle_on = 1'b1;
  endtask

  task automatic test_random_gestures();
    int unsigned spans [5] = '{8, 40, 300, 5000, 0};
    dar_cfg_t    c;
    int          target;
    int unsigned step;
    for (int ph = 0; ph < 5; ph++) begin
      wait_drained();
      // A zero span stands for the power-on timings, with clock steps to match.
      if (spans[ph] == 0) begin
        c = CFG_DEFAULTS;
        step = 2_000_000;
      end else begin
        c = draw_config(spans[ph]);
        step = spans[ph];
      end
      write_config(c);
      receiver_idle_on = ($urandom_range(0, 3) != 0);
      target = polls_sent + POLLS_PER_PHASE;
      while (polls_sent < target) begin
        sender_idle_on = ($urandom_range(0, 3) != 0);
        if ($urandom_range(0, 99) < 85)
          send_gesture($urandom_range(1, (spans[ph] == 0) ? 30 : 12), step);
        else
          send_noise(step);
      end
    end
    receiver_idle_on = 1'b1;
    sender_idle_on = 1'b1;
  endtask

  initial begin : receiver
    int stall;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (hold_off_req) begin
        out_ch.ready = 1'b0;
        for (int n = 0; n < HOLD_OFF_CYCLES; n++) @(negedge clk);
        hold_off_req = 1'b0;
      end
      stall = receiver_idle_on ? $urandom_range(0, 4) : 0;
      if (stall != 0) begin
        out_ch.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready = 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin : result_check
    nav_res_t want, got;
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got = {out_ch.vert_fire, out_ch.vert_is_down, out_ch.vert_fresh,
             out_ch.horiz_fire, out_ch.horiz_is_right, out_ch.horiz_fresh};
      if (pending_nav.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with no poll outstanding",
                                  results_checked));
      end else begin
        want = pending_nav.pop_front();
        check_flag("vert_fire", got.vert.fire, want.vert.fire);
        check_flag("vert_is_down", got.vert.pos, want.vert.pos);
        check_flag("vert_fresh", got.vert.fresh, want.vert.fresh);
        check_flag("horiz_fire", got.horiz.fire, want.horiz.fire);
        check_flag("horiz_is_right", got.horiz.pos, want.horiz.pos);
        check_flag("horiz_fresh", got.horiz.fresh, want.horiz.fresh);
        if (want.vert.fire || want.horiz.fire) fires_seen++;
      end
      results_checked++;
    end
  end

  always @(posedge clk) begin : watchdog
    if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Timeout: no item moved for %0d cycles, %0d results outstanding",
               QUIET_LIMIT, pending_nav.size());
      $display("Verification failed");
      $finish;
    end
  end

  initial begin : main
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = '0;
    cfg_data          = '0;
    in_ch.valid       = 1'b0;
    in_ch.hat_bits    = '0;
    in_ch.stick_x     = '0;
    in_ch.stick_y     = '0;
    in_ch.pad_buttons = '0;
    in_ch.now_ticks   = '0;
    poll_clock        = '0;
    model_cfg         = CFG_DEFAULTS;
    for (int ax = 0; ax < 2; ax++) begin
      held_dir[ax]   = DIR_NONE;
      next_fire[ax]  = '0;
      hold_start[ax] = '0;
    end
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n = 1'b1;

    test_directed_defaults();
    test_register_extremes();
    test_unmapped_register();
    test_backpressure();
    test_random_gestures();

    wait_drained();
    repeat (PIPE_DRAIN) @(posedge clk);
    if (pending_nav.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_nav.size()));
    $display("Sent %0d polls and checked %0d results, %0d of them with a navigation event.",
             polls_sent, results_checked, fires_seen);
    $display("Phases: power-on timings, register extremes, unmapped index, stalls, %s",
             "random held gestures under five timing sets.");
    if (errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

[files.f]
sv/dar_pkg.sv
sv/dar_if.sv
sv/dar_dir_decode.sv
sv/dar_axis.sv
sv/dpad_auto_repeat_accel.sv
tb/dpad_auto_repeat_accel_tb.sv
